@@ rtl/knob_volume_attenuator_serializer_macros.svh @@
// assertion macros used by the checker file
`ifndef KNOB_VOLUME_ATTENUATOR_SERIALIZER_MACROS_SVH
`define KNOB_VOLUME_ATTENUATOR_SERIALIZER_MACROS_SVH

// same-cycle implication, checked at every rising edge
`define KVAS_ASSERT_NOW(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked at every rising edge
`define KVAS_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/kvas_pkg.sv @@
// constants, opcodes and the attenuator word function for the knob volume block
package kvas_pkg;

    localparam int LEVEL_W = 7;
    localparam int STEP_W  = 16;
    localparam int WORD_W  = 11;
    localparam int PHASE_W = 6;
    localparam int BIT_W   = 4;
    localparam int CIDX_W  = 8;

    // knob event codes
    localparam logic [1:0] OP_UP   = 2'd1;
    localparam logic [1:0] OP_DOWN = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_LOW_LIMIT  = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_HIGH_LIMIT = 8'd1;

    localparam logic [LEVEL_W-1:0] LOW_LIMIT_RST  = 7'd30;
    localparam logic [LEVEL_W-1:0] HIGH_LIMIT_RST = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_RST      = 7'd40;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 7'd100;

    // serial phase numbers
    localparam logic [PHASE_W-1:0] PH_TRAIL_HI = 6'd44;
    localparam logic [PHASE_W-1:0] PH_TRAIL_LO = 6'd45;
    localparam logic [PHASE_W-1:0] PH_MUTE     = 6'd46;

    // level*83/100 as one constant multiply: 435169 / 2^19 ~ 0.83
    localparam logic [25:0] ATT_RECIP = 26'd435169;

    // attenuator word: coarse 21-att/4 in bits 2-6, fine 3-att%4 in bits 7-8
    function automatic logic [WORD_W-1:0] make_word(input logic [LEVEL_W-1:0] lvl);
        logic [25:0]        prod;
        logic [LEVEL_W-1:0] att;
        logic [4:0]         coarse;
        logic [1:0]         fine;
        prod   = {19'b0, lvl} * ATT_RECIP;
        att    = (lvl > LEVEL_MAX) ? 7'd0 : 7'(7'd83 - prod[25:19]);
        coarse = 5'(5'd21 - att[6:2]);
        fine   = 2'(2'd3 - att[1:0]);
        return {2'b11, fine, coarse, 2'b00};
    endfunction

endpackage

@@ rtl/knob_volume_attenuator_serializer.sv @@
// knob volume control: level tracking, attenuator word and serial pin phases
//
// Slave channel: one knob event per item, tuser = opcode (0 idle, 1 up, 2 down),
// tdata = step. Master channel: one pin phase per item, tlast on the final
// phase of an event. Config channel: index 0 low limit, 1 high limit, always
// ready; writes are expected only while the block is idle.
// An up or down event yields 46 phases (11 bits x 4, then data high with clock
// high and clock low), plus a 47th mute phase when the level ends at or below the
// low limit with the radio on. An idle event yields nothing, or the single mute phase.
// An event is held in an input register until the sequencer is free, then
// loaded into the level and word registers, which drive its first phase directly.
// The phase counter gives one phase per cycle while the receiver is ready; the
// next event waits in the input register and starts on the edge where the final
// phase is taken.
// When the receiver stalls, the phase counter and all result fields hold.
// Reset (synchronous, active low) restores level 40, radio off (muted), limits
// 30 and 100, and empties the input register and the output.
module knob_volume_attenuator_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // knob event channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] step
    input  logic [1:0]  i_s_tuser,   // [1:0] opcode
    // pin phase channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [0] data_pin, [1] clock_pin, [2] amp_mute,
                                     // [9:3] volume_now, [20:10] control_word, [23:21] zero
    output logic        o_m_tlast,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    logic [kvas_pkg::LEVEL_W-1:0] r_low_limit;
    logic [kvas_pkg::LEVEL_W-1:0] r_high_limit;
    logic [kvas_pkg::LEVEL_W-1:0] r_level;
    logic                         r_radio_off;
    logic                         r_in_vld;
    logic [1:0]                   r_in_op;
    logic [kvas_pkg::STEP_W-1:0]  r_in_step;
    logic                         r_busy;
    logic [kvas_pkg::PHASE_W-1:0] r_phase;
    logic [kvas_pkg::WORD_W-1:0]  r_word;
    logic                         r_mute_shift;
    logic                         r_ext;

    logic [kvas_pkg::LEVEL_W-1:0] n_level;
    logic                         n_mid_off;
    logic                         n_mute_evt;
    logic [kvas_pkg::WORD_W-1:0]  n_word;
    logic                         n_shift_op;
    logic [kvas_pkg::STEP_W:0]    up_sum;
    logic [kvas_pkg::STEP_W-1:0]  dn_step;
    logic [kvas_pkg::STEP_W:0]    dn_floor;
    logic                         out_fire;
    logic                         out_last;
    logic                         free;
    logic                         load;
    logic                         pin_data;
    logic                         pin_clock;
    logic                         pin_mute;
    logic [kvas_pkg::BIT_W-1:0]   bit_idx;

    assign o_s_tready  = !r_in_vld;
    assign o_cfg_ready = 1'b1;

    // level update for the held event
    always_comb begin
        up_sum     = {1'b0, r_in_step} + 17'(r_level);
        dn_step    = (r_in_step == '0) ? 16'd1 : r_in_step;
        dn_floor   = 17'(r_low_limit) + {1'b0, dn_step};
        n_level    = r_level;
        n_mid_off  = r_radio_off;
        n_shift_op = 1'b0;
        case (r_in_op)
            kvas_pkg::OP_UP: begin
                n_mid_off  = 1'b0;
                n_shift_op = 1'b1;
                if (r_level <= r_high_limit) begin
                    n_level = (up_sum > 17'(r_high_limit)) ? r_high_limit : up_sum[6:0];
                end else begin
                    n_level = r_high_limit;
                end
            end
            kvas_pkg::OP_DOWN: begin
                n_shift_op = 1'b1;
                if (r_level >= r_low_limit) begin
                    n_level = (17'(r_level) < dn_floor) ? r_low_limit
                                                        : 7'(r_level - dn_step[6:0]);
                end else begin
                    n_level = r_low_limit;
                end
            end
            default: begin
                n_level = r_level;
            end
        endcase
        n_mute_evt = (n_level <= r_low_limit) && !n_mid_off;
        n_word     = kvas_pkg::make_word(n_level);
    end

    // output handshake and load condition
    assign out_last = ((r_phase == kvas_pkg::PH_TRAIL_LO) && !r_ext)
                      || (r_phase == kvas_pkg::PH_MUTE);
    assign out_fire = r_busy && i_m_tready;
    assign free     = !r_busy || (out_fire && out_last);
    assign load     = r_in_vld && free;

    // input holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_op   <= i_s_tuser;
            r_in_step <= i_s_tdata;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= kvas_pkg::LOW_LIMIT_RST;
            r_high_limit <= kvas_pkg::HIGH_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kvas_pkg::CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_data;
                kvas_pkg::CFG_HIGH_LIMIT: r_high_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // level, radio state and phase sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= kvas_pkg::LEVEL_RST;
            r_radio_off <= 1'b1;
            r_busy      <= 1'b0;
            r_phase     <= '0;
        end else if (load) begin
            r_level     <= n_level;
            r_radio_off <= n_mute_evt | n_mid_off;
            if (n_shift_op) begin
                r_busy  <= 1'b1;
                r_phase <= '0;
            end else if (n_mute_evt) begin
                r_busy  <= 1'b1;
                r_phase <= kvas_pkg::PH_MUTE;
            end else begin
                r_busy  <= 1'b0;
            end
        end else if (out_fire) begin
            if (out_last) begin
                r_busy  <= 1'b0;
            end else begin
                r_phase <= r_phase + 6'd1;
            end
        end
    end

    // per-event payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word       <= n_word;
            r_mute_shift <= n_mid_off;
            r_ext        <= n_mute_evt;
        end
    end

    // pin levels for the current phase
    always_comb begin
        bit_idx   = r_phase[5:2];
        pin_data  = 1'b1;
        pin_clock = 1'b0;
        pin_mute  = r_mute_shift;
        if (r_phase < kvas_pkg::PH_TRAIL_HI) begin
            pin_data  = r_phase[1] & r_word[bit_idx];
            pin_clock = (r_phase[1:0] == 2'b11);
        end else if (r_phase == kvas_pkg::PH_TRAIL_HI) begin
            pin_clock = 1'b1;
        end else if (r_phase == kvas_pkg::PH_MUTE) begin
            pin_mute  = 1'b1;
        end
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tlast  = out_last;
    assign o_m_tdata  = {3'b000, r_word, r_level, pin_mute, pin_clock, pin_data};

endmodule

@@ rtl/kvas_checker.sv @@
// port-level checks for the knob volume block, bound to the top level
`include "knob_volume_attenuator_serializer_macros.svh"

module kvas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast
);

    // output is empty right after reset
    `KVAS_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_m_tvalid)

    // a stalled phase keeps its payload
    `KVAS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n && o_m_tvalid && !i_m_tready,
                      $stable(o_m_tdata) && $stable(o_m_tlast))

    // an event's phases run without gaps until the final one
    `KVAS_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n && o_m_tvalid && i_m_tready && !o_m_tlast,
                      o_m_tvalid)

    // every event ends with data high and clock low
    `KVAS_ASSERT_NOW(a_last_pins, i_clk, i_rst_n && o_m_tvalid && o_m_tlast,
                     o_m_tdata[0] && !o_m_tdata[1])

endmodule

bind knob_volume_attenuator_serializer kvas_checker u_kvas_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

@@ bench/tb.sv @@
// testbench for the knob volume attenuator serializer: directed and random knob events
`timescale 1ns / 1ps

module tb;

    // knob event codes and register indexes the package leaves out
    localparam logic [1:0]                  OP_IDLE        = 2'd0;
    localparam logic [1:0]                  OP_SPARE       = 2'd3;
    localparam logic [kvas_pkg::CIDX_W-1:0] CFG_UNUSED_IDX = 8'd2;
    localparam logic [kvas_pkg::CIDX_W-1:0] CFG_TOP_IDX    = 8'd255;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_PER_SET = 19;

    typedef struct {
        logic                         data_pin;
        logic                         clock_pin;
        logic                         amp_mute;
        logic [kvas_pkg::LEVEL_W-1:0] volume;
        logic [kvas_pkg::WORD_W-1:0]  word;
        logic                         last;
    } pin_phase_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data  = '0;

    // predicted state of the block
    logic [kvas_pkg::LEVEL_W-1:0] level_m     = kvas_pkg::LEVEL_RST;
    logic                         radio_off_m = 1'b1;
    logic [kvas_pkg::LEVEL_W-1:0] low_m       = kvas_pkg::LOW_LIMIT_RST;
    logic [kvas_pkg::LEVEL_W-1:0] high_m      = kvas_pkg::HIGH_LIMIT_RST;

    pin_phase_t pin_phase_q[$];
    int         mismatches   = 0;
    int         idle_cycles  = 0;
    int         stall_left   = 0;
    bit         send_gaps_on = 1'b1;
    bit         recv_stalls_on = 1'b1;

    knob_volume_attenuator_serializer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // attenuator word for a level: 83 - floor(level*83/100) split into coarse and fine
    function automatic logic [kvas_pkg::WORD_W-1:0] atten_word(
            input logic [kvas_pkg::LEVEL_W-1:0] lvl);
        int unsigned att;
        att = (lvl > kvas_pkg::LEVEL_MAX) ? 0 : 83 - (int'(lvl) * 83) / 100;
        return {2'b11, 2'(3 - att % 4), 5'(21 - att / 4), 2'b00};
    endfunction

    function automatic pin_phase_t make_phase(input logic d, input logic c,
                                              input logic [kvas_pkg::WORD_W-1:0] w);
        pin_phase_t p;
        p.data_pin  = d;
        p.clock_pin = c;
        p.amp_mute  = radio_off_m;
        p.volume    = level_m;
        p.word      = w;
        p.last      = 1'b0;
        return p;
    endfunction

    // level update, word shift-out and end-of-event mute for one accepted item
    task automatic model_knob_event(input logic [1:0] op, input logic [15:0] step);
        int          sum;
        int          diff;
        int          eff_step;
        logic [kvas_pkg::WORD_W-1:0] w;
        pin_phase_t  phases[$];
        if (op == kvas_pkg::OP_UP) begin
            radio_off_m = 1'b0;
            if (level_m <= high_m) begin
                sum = int'(level_m) + int'(step);
                level_m = (sum > int'(high_m)) ? high_m : 7'(sum);
            end else begin
                level_m = high_m;
            end
        end else if (op == kvas_pkg::OP_DOWN) begin
            eff_step = (step == 16'd0) ? 1 : int'(step);
            if (level_m >= low_m) begin
                diff = int'(level_m) - eff_step;
                level_m = (diff < int'(low_m)) ? low_m : 7'(diff);
            end else begin
                level_m = low_m;
            end
        end
        w = atten_word(level_m);
        if (op == kvas_pkg::OP_UP || op == kvas_pkg::OP_DOWN) begin
            for (int b = 0; b < kvas_pkg::WORD_W; b++) begin
                phases.push_back(make_phase(1'b0, 1'b0, w));
                phases.push_back(make_phase(1'b0, 1'b0, w));
                phases.push_back(make_phase(w[b], 1'b0, w));
                phases.push_back(make_phase(w[b], 1'b1, w));
            end
            phases.push_back(make_phase(1'b1, 1'b1, w));
            phases.push_back(make_phase(1'b1, 1'b0, w));
        end
        if (level_m <= low_m && !radio_off_m) begin
            radio_off_m = 1'b1;
            phases.push_back(make_phase(1'b1, 1'b0, w));
        end
        if (phases.size() > 0)
            phases[phases.size() - 1].last = 1'b1;
        foreach (phases[k])
            pin_phase_q.push_back(phases[k]);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatches < 40)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    // one knob event item, after a random gap
    task automatic send_event(input logic [1:0] op, input logic [15:0] step);
        int gap;
        gap = pick_gap(send_gaps_on);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= step;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        model_knob_event(op, step);
    endtask

    // drain every expected item, then let an idle event settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pin_phase_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kvas_pkg::CIDX_W-1:0] idx,
                             input logic [kvas_pkg::LEVEL_W-1:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == kvas_pkg::CFG_LOW_LIMIT)
            low_m = val;
        else if (idx == kvas_pkg::CFG_HIGH_LIMIT)
            high_m = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // reset limits: step 0 both ways, idle codes, saturation at both ends
    task automatic test_reset_defaults();
        send_event(kvas_pkg::OP_UP, 16'd0);
        send_event(OP_IDLE, 16'hFFFF);
        send_event(OP_SPARE, 16'h5A5A);
        send_event(kvas_pkg::OP_DOWN, 16'd0);
        send_event(kvas_pkg::OP_DOWN, 16'hFFFF);
        send_event(kvas_pkg::OP_UP, 16'hFFFF);
        send_event(kvas_pkg::OP_UP, 16'd1);
        send_event(kvas_pkg::OP_DOWN, 16'd1);
    endtask

    // low above high, plus writes to indexes that hold no register
    task automatic test_crossed_limits();
        write_reg(kvas_pkg::CFG_LOW_LIMIT, 7'd100);
        write_reg(kvas_pkg::CFG_HIGH_LIMIT, 7'd0);
        write_reg(CFG_UNUSED_IDX, 7'h7F);
        write_reg(CFG_TOP_IDX, 7'h00);
        send_event(kvas_pkg::OP_UP, 16'd5);
        send_event(kvas_pkg::OP_DOWN, 16'd3);
        send_event(kvas_pkg::OP_UP, 16'd0);
    endtask

    // zero low limit: level 0 gives the deepest attenuation
    task automatic test_zero_low_limit();
        write_reg(kvas_pkg::CFG_LOW_LIMIT, 7'd0);
        write_reg(kvas_pkg::CFG_HIGH_LIMIT, 7'd100);
        send_event(kvas_pkg::OP_UP, 16'd0);
        send_event(kvas_pkg::OP_UP, 16'd100);
        send_event(kvas_pkg::OP_DOWN, 16'hFFFF);
        send_event(kvas_pkg::OP_UP, 16'd50);
    endtask

    // raising the low limit over a playing level mutes on the next idle item
    task automatic test_idle_mute();
        write_reg(kvas_pkg::CFG_LOW_LIMIT, 7'd60);
        send_event(OP_IDLE, 16'd0);
        send_event(OP_SPARE, 16'd0);
        send_event(kvas_pkg::OP_UP, 16'd64);
        write_reg(kvas_pkg::CFG_HIGH_LIMIT, 7'd64);
        send_event(kvas_pkg::OP_UP, 16'd1);
        send_event(kvas_pkg::OP_DOWN, 16'd4);
    endtask

    // random events over several limit settings, idling on and off
    task automatic test_random_knob();
        int low_set[7]  = '{30, 0, 100, 50, 80, 0, 0};
        int high_set[7] = '{100, 100, 100, 60, 20, 0, 0};
        int sent;
        int r;
        logic [1:0]  op;
        logic [15:0] step;
        low_set[6]  = $urandom_range(0, 100);
        high_set[6] = $urandom_range(0, 100);
        for (int s = 0; s < 7; s++) begin
            write_reg(kvas_pkg::CFG_LOW_LIMIT, 7'(low_set[s]));
            write_reg(kvas_pkg::CFG_HIGH_LIMIT, 7'(high_set[s]));
            if ($urandom_range(0, 2) == 0)
                write_reg(8'($urandom_range(2, 255)), 7'($urandom_range(0, 127)));
            send_gaps_on   = (s != 2);
            recv_stalls_on = (s != 2);
            sent = 0;
            while (sent < RANDOM_PER_SET) begin
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    op = (r < 45) ? kvas_pkg::OP_UP : kvas_pkg::OP_DOWN;
                    sent++;
                end else begin
                    op = (r < 93) ? OP_IDLE : OP_SPARE;
                end
                r = $urandom_range(0, 99);
                if (r < 50)
                    step = 16'($urandom_range(0, 15));
                else if (r < 80)
                    step = 16'($urandom_range(0, 120));
                else
                    step = 16'($urandom_range(0, 65535));
                send_event(op, step);
            end
        end
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap(recv_stalls_on);
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // compare each pin phase item with the oldest prediction
    always @(posedge i_clk) begin : check_phase
        pin_phase_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pin_phase_q.size() == 0) begin
                report_mismatch("unexpected item, tdata", int'(o_m_tdata), 0);
            end else begin
                want = pin_phase_q.pop_front();
                if (o_m_tdata[0] !== want.data_pin)
                    report_mismatch("data_pin", int'(o_m_tdata[0]), int'(want.data_pin));
                if (o_m_tdata[1] !== want.clock_pin)
                    report_mismatch("clock_pin", int'(o_m_tdata[1]), int'(want.clock_pin));
                if (o_m_tdata[2] !== want.amp_mute)
                    report_mismatch("amp_mute", int'(o_m_tdata[2]), int'(want.amp_mute));
                if (o_m_tdata[9:3] !== want.volume)
                    report_mismatch("volume_now", int'(o_m_tdata[9:3]), int'(want.volume));
                if (o_m_tdata[20:10] !== want.word)
                    report_mismatch("control_word", int'(o_m_tdata[20:10]), int'(want.word));
                if (o_m_tdata[23:21] !== 3'b000)
                    report_mismatch("tdata padding", int'(o_m_tdata[23:21]), 0);
                if (o_m_tlast !== want.last)
                    report_mismatch("tlast", int'(o_m_tlast), int'(want.last));
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_crossed_limits();
        test_zero_low_limit();
        test_idle_mute();
        test_random_knob();
        wait_idle();
        if (pin_phase_q.size() != 0)
            report_mismatch("items never produced", 0, pin_phase_q.size());
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ knob_volume_attenuator_serializer.f @@
+incdir+rtl
rtl/kvas_pkg.sv
rtl/knob_volume_attenuator_serializer.sv
rtl/kvas_checker.sv
bench/tb.sv
